FILE: hw/rtl/nmea_rmc_pkg.sv
// Shared types and character constants for the NMEA RMC field extractor.
// No dependencies; used by nmea_rmc_step and nmea_rmc_field_extractor.
package nmea_rmc_pkg;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;  // '$'
    localparam logic [7:0] CH_M       = 8'h4D;  // 'M'
    localparam logic [7:0] CH_C       = 8'h43;  // 'C'
    localparam logic [7:0] CH_NEWLINE = 8'h0A;  // '\n'
    localparam logic [7:0] CH_A       = 8'h41;  // 'A'
    localparam logic [7:0] CH_V       = 8'h56;  // 'V'
    localparam logic [7:0] CH_COMMA   = 8'h2C;  // ','

    localparam logic [2:0] FIELD_LAST  = 3'd7;
    localparam logic [2:0] FIELD_STAT  = 3'd2;
    localparam logic [3:0] INDEX_LAST  = 4'd15;

    localparam int TDATA_W = 24;

    // Per-frame state, apart from the frame position (its width follows MAX_LEN).
    typedef struct packed {
        logic       dollar_at_start;
        logic       m_at_four;
        logic       c_at_five;
        logic [2:0] field_number;
        logic [3:0] field_char_count;
        logic [7:0] status_char;
        logic       fix_latch;
    } frame_state_t;

    // One result; packed so that data_byte lands in the low bits of tdata.
    typedef struct packed {
        logic       overflow;
        logic       fix_valid;
        logic       is_rmc;
        logic       is_delimiter;
        logic [3:0] char_index;
        logic [2:0] field_tag;
        logic [7:0] data_byte;
    } result_t;

endpackage

FILE: hw/rtl/nmea_rmc_step.sv
// Per-byte update: header check, comma counting, status capture, fix latch.
// Purely combinational; depends on nmea_rmc_pkg.
module nmea_rmc_step #(
    parameter int MAX_LEN = 256,
    parameter int POS_W   = $clog2(MAX_LEN + 1)
) (
    input  logic [7:0]                 rx_byte,
    input  nmea_rmc_pkg::frame_state_t state_cur,
    input  logic [POS_W-1:0]           pos_cur,
    output nmea_rmc_pkg::frame_state_t state_nxt,
    output logic [POS_W-1:0]           pos_nxt,
    output nmea_rmc_pkg::result_t      res,
    output logic                       frame_done
);

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

    logic                       is_dollar;
    logic                       is_comma;
    logic                       done;
    logic                       rmc;
    logic [POS_W-1:0]           pos_a;
    logic [POS_W-1:0]           pos_b;
    nmea_rmc_pkg::frame_state_t st;

    always_comb begin
        is_dollar = (rx_byte == nmea_rmc_pkg::CH_DOLLAR);
        is_comma  = (rx_byte == nmea_rmc_pkg::CH_COMMA);
        st        = state_cur;
        pos_a     = pos_cur;

        // '$' restarts the frame (fix latch survives)
        if (is_dollar) begin
            st.dollar_at_start  = 1'b0;
            st.m_at_four        = 1'b0;
            st.c_at_five        = 1'b0;
            st.field_number     = '0;
            st.field_char_count = '0;
            st.status_char      = '0;
            pos_a               = '0;
        end

        // header check, position saturates at MAX_LEN
        pos_b = pos_a;
        if (pos_a < POS_MAX) begin
            if (pos_a == POS_W'(0)) st.dollar_at_start = is_dollar;
            if (pos_a == POS_W'(4)) st.m_at_four = (rx_byte == nmea_rmc_pkg::CH_M);
            if (pos_a == POS_W'(5)) st.c_at_five = (rx_byte == nmea_rmc_pkg::CH_C);
            pos_b = pos_a + POS_W'(1);
        end

        res.data_byte    = rx_byte;
        res.field_tag    = st.field_number;
        res.char_index   = st.field_char_count;
        res.is_delimiter = is_comma;
        res.overflow     = (pos_b == POS_MAX);

        if (is_comma) begin
            if (st.field_number != nmea_rmc_pkg::FIELD_LAST) begin
                st.field_number = st.field_number + 3'd1;
            end
            st.field_char_count = '0;
        end else begin
            if (st.field_number == nmea_rmc_pkg::FIELD_STAT && st.field_char_count == 4'd0) begin
                st.status_char = rx_byte;
            end
            if (st.field_char_count != nmea_rmc_pkg::INDEX_LAST) begin
                st.field_char_count = st.field_char_count + 4'd1;
            end
        end

        rmc  = st.dollar_at_start && st.m_at_four && st.c_at_five;
        done = rmc && (rx_byte == nmea_rmc_pkg::CH_NEWLINE);
        res.is_rmc = rmc;

        if (done) begin
            if (st.status_char == nmea_rmc_pkg::CH_A) begin
                st.fix_latch = 1'b1;
            end else if (st.status_char == nmea_rmc_pkg::CH_V) begin
                st.fix_latch = 1'b0;
            end
            st.dollar_at_start  = 1'b0;
            st.m_at_four        = 1'b0;
            st.c_at_five        = 1'b0;
            st.field_number     = '0;
            st.field_char_count = '0;
            st.status_char      = '0;
            pos_b               = '0;
        end

        res.fix_valid = st.fix_latch;
        state_nxt     = st;
        pos_nxt       = pos_b;
        frame_done    = done;
    end

endmodule

FILE: hw/rtl/nmea_rmc_field_extractor.sv
// Top level of the NMEA RMC field extractor: input register, per-byte step, result register.
// Depends on nmea_rmc_pkg and nmea_rmc_step.
//
// A byte moves from the input register into the result register, which drives m_tvalid.
// Throughput: one byte per cycle while m_tready is high; frame state updates as each byte advances.
// Reset (aresetn low, synchronous): both stages empty, frame position, header flags,
// field counters, status character and fix latch cleared to zero.
module nmea_rmc_field_extractor #(
    parameter int MAX_LEN = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream: one received character per transfer
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream: one tagged character per transfer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [10:8] field_tag, [14:11] char_index,
                                   // [15] is_delimiter, [16] is_rmc, [17] fix_valid,
                                   // [18] overflow, [23:19] zero
    output logic        m_tlast    // frame_done: newline that closes an RMC frame
);

    localparam int POS_W = $clog2(MAX_LEN + 1);

    // input stage
    logic                       in_valid_reg, in_valid_next;
    logic [7:0]                 in_byte_reg;
    // frame state, updated as each byte leaves the input stage
    nmea_rmc_pkg::frame_state_t state_reg, state_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    // result stage
    logic                       out_valid_reg, out_valid_next;
    nmea_rmc_pkg::result_t      out_reg, out_next;
    logic                       out_done_reg, out_done_next;

    logic advance;   // input stage moves into result stage this cycle

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    nmea_rmc_step #(
        .MAX_LEN (MAX_LEN),
        .POS_W   (POS_W)
    ) u_step (
        .rx_byte    (in_byte_reg),
        .state_cur  (state_reg),
        .pos_cur    (pos_reg),
        .state_nxt  (state_next),
        .pos_nxt    (pos_next),
        .res        (out_next),
        .frame_done (out_done_next)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            pos_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
                pos_reg   <= pos_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_reg      <= out_next;
            out_done_reg <= out_done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(nmea_rmc_pkg::TDATA_W - $bits(nmea_rmc_pkg::result_t))'(0), out_reg};
    assign m_tlast  = out_done_reg;

    // frame_done only ever closes a recognized RMC frame on a newline
    a_done_is_rmc_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
        (out_reg.is_rmc && out_reg.data_byte == nmea_rmc_pkg::CH_NEWLINE))
        else $error("frame_done without RMC newline");

    // delimiter flag tracks the comma character
    a_delim_comma: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.is_delimiter == (out_reg.data_byte == nmea_rmc_pkg::CH_COMMA)))
        else $error("is_delimiter mismatch");

    // after a completed frame the frame counters restart
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && out_done_next) |=> (pos_reg == '0 && state_reg.field_number == 3'd0))
        else $error("frame state not cleared after frame_done");

    // the position never runs past the buffer length
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_LEN))
        else $error("frame position beyond MAX_LEN");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

FILE: test/rmc_tag_checker.sv
`timescale 1ns / 100ps
// Checker for the NMEA RMC field extractor: watches both streams, predicts each tagged character.
// Depends on nmea_rmc_pkg for the result layout and character codes.
module rmc_tag_checker #(
    parameter int MAX_LEN = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] data_byte .. [18] overflow, [23:19] zero
    input  logic        m_tlast,   // frame_done
    output int          error_count,
    output int          outstanding,
    output int          result_count,
    output int          frame_count,
    output int          overflow_count
);

    typedef struct {
        nmea_rmc_pkg::result_t res;
        logic                  frame_done;
    } predicted_char_t;

    predicted_char_t predicted_chars[$];
    predicted_char_t want;

    // predictor's own copy of the frame state
    int         frame_pos;
    logic       saw_dollar, saw_m, saw_c;
    logic [2:0] field_no;
    logic [3:0] char_no;
    logic [7:0] status_byte;
    logic       fix_held;

    initial begin
        error_count    = 0;
        outstanding    = 0;
        result_count   = 0;
        frame_count    = 0;
        overflow_count = 0;
    end

    task automatic clear_frame_state();
        frame_pos   = 0;
        saw_dollar  = 1'b0;
        saw_m       = 1'b0;
        saw_c       = 1'b0;
        field_no    = '0;
        char_no     = '0;
        status_byte = '0;
    endtask

    task automatic tag_char(input logic [7:0] c, output predicted_char_t p);
        if (c == nmea_rmc_pkg::CH_DOLLAR) begin
            clear_frame_state();
        end

        // header check; the position sticks at MAX_LEN
        if (frame_pos < MAX_LEN) begin
            if (frame_pos == 0) saw_dollar = (c == nmea_rmc_pkg::CH_DOLLAR);
            if (frame_pos == 4) saw_m = (c == nmea_rmc_pkg::CH_M);
            if (frame_pos == 5) saw_c = (c == nmea_rmc_pkg::CH_C);
            frame_pos++;
        end
        p.res.overflow = (frame_pos >= MAX_LEN);

        // a comma carries the tag of the field it closes
        p.res.data_byte    = c;
        p.res.field_tag    = field_no;
        p.res.char_index   = char_no;
        p.res.is_delimiter = (c == nmea_rmc_pkg::CH_COMMA);
        if (c == nmea_rmc_pkg::CH_COMMA) begin
            if (field_no != nmea_rmc_pkg::FIELD_LAST) field_no++;
            char_no = '0;
        end else begin
            if (p.res.field_tag == nmea_rmc_pkg::FIELD_STAT && p.res.char_index == 0)
                status_byte = c;
            if (char_no != nmea_rmc_pkg::INDEX_LAST) char_no++;
        end

        p.res.is_rmc = saw_dollar && saw_m && saw_c;
        p.frame_done = p.res.is_rmc && (c == nmea_rmc_pkg::CH_NEWLINE);
        if (p.frame_done) begin
            if (status_byte == nmea_rmc_pkg::CH_A) fix_held = 1'b1;
            else if (status_byte == nmea_rmc_pkg::CH_V) fix_held = 1'b0;
            clear_frame_state();
        end
        p.res.fix_valid = fix_held;
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            error_count++;
            $display("%0t: result %0d, %s mismatch: expected %0d, actual %0d",
                     $time, result_count, name, exp_val, act_val);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_frame_state();
            fix_held = 1'b0;
            predicted_chars.delete();
        end else begin
            // push before pop so a same-edge transfer pair stays in order
            if (s_tvalid && s_tready) begin
                tag_char(s_tdata, want);
                predicted_chars.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                result_count++;
                if (m_tlast) frame_count++;
                if (m_tdata[18]) overflow_count++;
                if (predicted_chars.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual tdata 0x%06h last %0b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = predicted_chars.pop_front();
                    check_field("data_byte", want.res.data_byte, m_tdata[7:0]);
                    check_field("field_tag", want.res.field_tag, m_tdata[10:8]);
                    check_field("char_index", want.res.char_index, m_tdata[14:11]);
                    check_field("is_delimiter", want.res.is_delimiter, m_tdata[15]);
                    check_field("is_rmc", want.res.is_rmc, m_tdata[16]);
                    check_field("fix_valid", want.res.fix_valid, m_tdata[17]);
                    check_field("overflow", want.res.overflow, m_tdata[18]);
                    check_field("tdata padding", 0, m_tdata[23:19]);
                    check_field("frame_done", want.frame_done, m_tlast);
                end
            end
        end
        outstanding <= predicted_chars.size();
    end

endmodule

FILE: test/tb_nmea_rmc_field_extractor.sv
`timescale 1ns / 100ps
// Testbench top for the NMEA RMC field extractor: clock, reset, character stimulus, verdict.
// Depends on nmea_rmc_pkg, nmea_rmc_field_extractor and rmc_tag_checker.
module tb_nmea_rmc_field_extractor;

    localparam int MAX_LEN   = 256;
    localparam int ITEM_GOAL = 1600;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [7:0] data_byte, [10:8] field_tag, [14:11] char_index,
                                     // [15] is_delimiter, [16] is_rmc, [17] fix_valid,
                                     // [18] overflow, [23:19] zero
    logic        m_tlast;            // frame_done

    int error_count, outstanding, result_count, frame_count, overflow_count;
    int sent_count = 0;
    bit quiet      = 1'b0;           // when set, neither side idles

    nmea_rmc_field_extractor #(.MAX_LEN(MAX_LEN)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    rmc_tag_checker #(.MAX_LEN(MAX_LEN)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .error_count    (error_count),
        .outstanding    (outstanding),
        .result_count   (result_count),
        .frame_count    (frame_count),
        .overflow_count (overflow_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side backpressure: ~29% stall, none during the quiet stretch.
    always @(posedge aclk) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 29);
    end

    // Mostly characters that appear in real RMC fields, now and then any byte at all.
    function automatic logic [7:0] field_char();
        string pool = "0123456789.NSEW";
        if ($urandom_range(99) < 4) return 8'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    // One transfer on the input stream, with random idle cycles ahead of it.
    // tvalid is left high after the transfer; the next call or the end lowers it.
    task automatic send_char(input logic [7:0] c);
        while (!quiet && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // A sentence with an RMC-shaped header (sometimes spoiled at position 4 or 5),
    // a random number of fields, a status of A, V, junk or nothing, and usually a newline.
    // An overlong one runs the frame position into saturation before the newline.
    task automatic send_sentence(input bit overlong);
        int nfields;
        int len;
        int pick;
        send_char(nmea_rmc_pkg::CH_DOLLAR);
        repeat (3) send_char(8'($urandom_range(65, 90)));
        send_char(($urandom_range(9) == 0) ? field_char() : nmea_rmc_pkg::CH_M);
        send_char(($urandom_range(9) == 0) ? field_char() : nmea_rmc_pkg::CH_C);
        nfields = $urandom_range(0, 12);
        for (int f = 1; f <= nfields; f++) begin
            send_char(nmea_rmc_pkg::CH_COMMA);
            if (f == nmea_rmc_pkg::FIELD_STAT) begin
                pick = $urandom_range(9);
                if (pick < 4) send_char(nmea_rmc_pkg::CH_A);
                else if (pick < 7) send_char(nmea_rmc_pkg::CH_V);
                else if (pick < 8) send_char(field_char());
                // otherwise an empty status field
            end else begin
                // long fields now and then, to push char_index into saturation
                len = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 6);
                repeat (len) send_char(field_char());
            end
        end
        if (overlong) repeat ($urandom_range(MAX_LEN, MAX_LEN + 40)) send_char(field_char());
        if ($urandom_range(9) != 0) send_char(nmea_rmc_pkg::CH_NEWLINE);
    endtask

    initial begin
        int sentences;
        int pick;
        sentences = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part:
        //  - byte extremes and a newline outside any frame (ordinary bytes)
        //  - RMC frame with empty time, status A, field counter saturating past E/W
        //  - RMC frame with empty time and status V, which clears the fix again
        send_char(8'h00);
        send_char(nmea_rmc_pkg::CH_NEWLINE);
        send_char(8'hFF);
        send_text("$ZZZMC,,A,,,,,,\n");
        send_text("$GPRMC,,V\n");

        // Random part: mostly well-formed sentences with random content, plus bursts
        // of noise bytes. The third sentence is always overlong so overflow is reached.
        while (sent_count < ITEM_GOAL) begin
            quiet = (sent_count >= 600 && sent_count < 900);
            pick  = $urandom_range(99);
            if (pick < 20) begin
                repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
            end else begin
                send_sentence(sentences == 2 || pick < 22);
                sentences++;
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // drain: the checker's count is registered, hence the extra edge first
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d characters in %0d sentences plus noise; checked %0d results.",
                 sent_count, sentences, result_count);
        $display("Saw %0d completed RMC frames and %0d results with position overflow.",
                 frame_count, overflow_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
